@@ rtl/clpc_pkg.sv @@
// Package: widths, request codes and payload types of the circular log pointer controller.
package clpc_pkg;

   localparam int unsigned LEN_W    = 17;
   localparam int unsigned OFF_W    = 18;
   localparam int unsigned CODE_W   = 2;
   localparam int unsigned CALC_W   = 20;

   localparam logic [LEN_W-1:0] CAPACITY_LIMIT = 17'd65536;
   localparam logic [LEN_W-1:0] CAPACITY_MIN   = 17'd1;

   localparam logic [CODE_W-1:0] KIND_WRITE = 2'd0;
   localparam logic [CODE_W-1:0] KIND_READ  = 2'd1;
   localparam logic [CODE_W-1:0] KIND_SEEK  = 2'd2;

   localparam logic [CODE_W-1:0] WHENCE_CURRENT = 2'd0;
   localparam logic [CODE_W-1:0] WHENCE_END     = 2'd1;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef struct packed {
      logic [CODE_W-1:0]       kind;
      logic [LEN_W-1:0]        request_length;
      logic signed [OFF_W-1:0] seek_offset;
      logic [CODE_W-1:0]       seek_whence;
   } req_type;

   typedef struct packed {
      logic             status;
      logic [LEN_W-1:0] transfer_count;
      logic [LEN_W-1:0] first_start;
      logic [LEN_W-1:0] first_length;
      logic [LEN_W-1:0] second_length;
      logic [LEN_W-1:0] position_after;
   } rsp_type;

   // zero-extend an unsigned length into the signed working width
   function automatic logic signed [CALC_W-1:0] to_calc(input logic [LEN_W-1:0] v);
      to_calc = $signed({{(CALC_W-LEN_W){1'b0}}, v});
   endfunction

   // sign-extend a seek offset into the signed working width
   function automatic logic signed [CALC_W-1:0] off_to_calc(input logic signed [OFF_W-1:0] v);
      off_to_calc = $signed({{(CALC_W-OFF_W){v[OFF_W-1]}}, v});
   endfunction

endpackage

@@ rtl/clpc_ifs.sv @@
// Interfaces: request, response and capacity write channels.
interface clpc_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [clpc_pkg::CODE_W-1:0]             kind;
   logic [clpc_pkg::LEN_W-1:0]              request_length;
   logic signed [clpc_pkg::OFF_W-1:0]       seek_offset;
   logic [clpc_pkg::CODE_W-1:0]             seek_whence;

   modport source (output valid, kind, request_length, seek_offset, seek_whence,
                   input ready);
   modport sink   (input valid, kind, request_length, seek_offset, seek_whence,
                   output ready);
endinterface

interface clpc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          status;
   logic [clpc_pkg::LEN_W-1:0]    transfer_count;
   logic [clpc_pkg::LEN_W-1:0]    first_start;
   logic [clpc_pkg::LEN_W-1:0]    first_length;
   logic [clpc_pkg::LEN_W-1:0]    second_length;
   logic [clpc_pkg::LEN_W-1:0]    position_after;

   modport source (output valid, status, transfer_count, first_start, first_length,
                   second_length, position_after, input ready);
   modport sink   (input valid, status, transfer_count, first_start, first_length,
                   second_length, position_after, output ready);
endinterface

interface clpc_csr_if;
   logic                          valid;
   logic                          ready;
   logic [clpc_pkg::LEN_W-1:0]    capacity;

   modport source (output valid, capacity, input ready);
   modport sink   (input valid, capacity, output ready);
endinterface

@@ rtl/circular_log_pointer_controller_core.sv @@
// Top level: pointer control of an overwriting circular log region.
//
//   channel  | dir | beat moves                                   | handshake
//   ---------+-----+----------------------------------------------+-----------
//   req_ch   | in  | kind, request_length, seek_offset, whence    | valid/ready
//   rsp_ch   | out | status, counts, segments, position_after     | valid/ready
//   csr_ch   | in  | capacity                                     | valid/ready
//
// One request per cycle while the response is not stalled: a beat is held in the
// input register, resolved against the pointer registers combinationally and lands
// in the response register. Both stages hold when the response is stalled; the
// input stage still takes a beat while it is empty.
// Reset and a capacity write clear position, end mark, wrapped flag and fill count.
module circular_log_pointer_controller_core (
   input  logic               clock,
   input  logic               reset,
   clpc_req_if.sink           req_ch,
   clpc_rsp_if.source         rsp_ch,
   clpc_csr_if.sink           csr_ch
);

   localparam int unsigned LW = clpc_pkg::LEN_W;
   localparam int unsigned CW = clpc_pkg::CALC_W;
   // signed zero so compares stay signed
   localparam logic signed [CW-1:0] ZERO_S = '0;

   logic                  in_v_ff, in_v_in;
   clpc_pkg::req_type     in_req_ff;
   logic                  out_v_ff, out_v_in;
   clpc_pkg::rsp_type     out_rsp_ff;
   clpc_pkg::rsp_type     res;

   logic [LW-1:0] cap_ff, cap_in;
   logic [LW-1:0] pos_ff, pos_in;
   logic [LW-1:0] end_ff, end_in;
   logic          wrap_ff, wrap_in;
   logic [LW-1:0] fill_ff, fill_in;

   logic advance, req_take, csr_take, commit;

   logic signed [CW-1:0] cap_s, pos_s, end_s, fill_s, len_s, off_s;
   logic signed [CW-1:0] ahead_s, room_s, total_s, held_s, cnt_s, fl_s, np_s, f_s;
   logic rej, upd_end, set_wrap, upd_fill;

   assign advance  = !out_v_ff || rsp_ch.ready;
   assign req_take = req_ch.valid && req_ch.ready;
   assign csr_take = csr_ch.valid && csr_ch.ready;
   assign commit   = advance && in_v_ff && !rej;

   assign req_ch.ready = !in_v_ff || advance;
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cap_s   = clpc_pkg::to_calc(cap_ff);
      pos_s   = clpc_pkg::to_calc(pos_ff);
      end_s   = clpc_pkg::to_calc(end_ff);
      fill_s  = clpc_pkg::to_calc(fill_ff);
      len_s   = clpc_pkg::to_calc(in_req_ff.request_length);
      off_s   = clpc_pkg::off_to_calc(in_req_ff.seek_offset);
      ahead_s = (end_s >= pos_s) ? (end_s - pos_s) : (cap_s - pos_s + end_s);
      total_s = (fill_s < cap_s) ? fill_s : cap_s;
      held_s  = wrap_ff ? cap_s : fill_s;
      rej      = 1'b0;
      upd_end  = 1'b0;
      set_wrap = 1'b0;
      upd_fill = 1'b0;
      room_s   = '0;
      cnt_s    = '0;
      fl_s     = '0;
      np_s     = pos_s;
      f_s      = fill_s;
      case (in_req_ff.kind)
         clpc_pkg::KIND_WRITE: begin
            room_s = cap_s - pos_s;
            cnt_s  = len_s;
            if (len_s == ZERO_S || len_s > cap_s) begin
               rej = 1'b1;
            end else begin
               if (room_s >= len_s) begin
                  fl_s = len_s;
                  np_s = pos_s + len_s;
               end else begin
                  fl_s     = room_s;
                  np_s     = len_s - room_s;
                  set_wrap = 1'b1;
               end
               upd_end = (ahead_s < len_s);
               if (fill_s < cap_s) begin
                  upd_fill = 1'b1;
                  f_s      = ((fill_s + len_s) > cap_s) ? cap_s : (fill_s + len_s);
               end
            end
         end
         clpc_pkg::KIND_READ: begin
            room_s = total_s - pos_s;
            cnt_s  = (ahead_s > len_s) ? len_s : ahead_s;
            if (len_s == ZERO_S) begin
               rej = 1'b1;
            end else if (room_s >= cnt_s) begin
               fl_s = cnt_s;
               np_s = pos_s + cnt_s;
            end else if (room_s >= ZERO_S) begin
               fl_s = room_s;
               np_s = cnt_s - room_s;
            end else begin
               rej = 1'b1;
            end
         end
         clpc_pkg::KIND_SEEK: begin
            if (in_req_ff.seek_whence == clpc_pkg::WHENCE_END) begin
               if (off_s > ZERO_S || (held_s + off_s) < ZERO_S) begin
                  rej = 1'b1;
               end else begin
                  np_s = end_s + off_s;
                  if (np_s < ZERO_S) np_s = np_s + cap_s;
               end
            end else if (in_req_ff.seek_whence == clpc_pkg::WHENCE_CURRENT) begin
               if (off_s > held_s || off_s < -held_s) begin
                  rej = 1'b1;
               end else begin
                  np_s = pos_s + off_s;
                  if (np_s < ZERO_S) np_s = np_s + cap_s;
                  if (np_s > cap_s) np_s = np_s - cap_s;
               end
            end else begin
               rej = 1'b1;
            end
            // clamp into the region
            if (np_s < ZERO_S) np_s = ZERO_S;
            if (np_s > cap_s) np_s = cap_s;
         end
         default: begin
            rej = 1'b1;
         end
      endcase

      res.status         = rej ? clpc_pkg::STATUS_REJECT : clpc_pkg::STATUS_OK;
      res.transfer_count = '0;
      res.first_start    = '0;
      res.first_length   = '0;
      res.second_length  = '0;
      res.position_after = pos_ff;
      if (!rej) begin
         res.position_after = np_s[LW-1:0];
         if (in_req_ff.kind != clpc_pkg::KIND_SEEK) begin
            res.transfer_count = cnt_s[LW-1:0];
            res.first_start    = pos_ff;
            res.first_length   = fl_s[LW-1:0];
            res.second_length  = cnt_s[LW-1:0] - fl_s[LW-1:0];
         end
      end
   end

   always_comb begin
      in_v_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_v_ff);
      out_v_in = advance ? in_v_ff : out_v_ff;
      cap_in   = cap_ff;
      pos_in   = pos_ff;
      end_in   = end_ff;
      wrap_in  = wrap_ff;
      fill_in  = fill_ff;
      if (csr_take) begin
         // region restarts with the new size, limited to 1..CAPACITY_LIMIT
         if (csr_ch.capacity == '0) begin
            cap_in = clpc_pkg::CAPACITY_MIN;
         end else if (csr_ch.capacity > clpc_pkg::CAPACITY_LIMIT) begin
            cap_in = clpc_pkg::CAPACITY_LIMIT;
         end else begin
            cap_in = csr_ch.capacity;
         end
         pos_in  = '0;
         end_in  = '0;
         wrap_in = 1'b0;
         fill_in = '0;
      end else if (commit) begin
         pos_in = np_s[LW-1:0];
         if (upd_end)  end_in  = np_s[LW-1:0];
         if (set_wrap) wrap_in = 1'b1;
         if (upd_fill) fill_in = f_s[LW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         cap_ff   <= clpc_pkg::CAPACITY_LIMIT;
         pos_ff   <= '0;
         end_ff   <= '0;
         wrap_ff  <= 1'b0;
         fill_ff  <= '0;
      end else begin
         in_v_ff  <= in_v_in;
         out_v_ff <= out_v_in;
         cap_ff   <= cap_in;
         pos_ff   <= pos_in;
         end_ff   <= end_in;
         wrap_ff  <= wrap_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_req_ff.kind           <= req_ch.kind;
         in_req_ff.request_length <= req_ch.request_length;
         in_req_ff.seek_offset    <= req_ch.seek_offset;
         in_req_ff.seek_whence    <= req_ch.seek_whence;
      end
      // hold the response while the sink stalls
      if (advance) begin
         out_rsp_ff <= res;
      end
   end

   assign rsp_ch.valid          = out_v_ff;
   assign rsp_ch.status         = out_rsp_ff.status;
   assign rsp_ch.transfer_count = out_rsp_ff.transfer_count;
   assign rsp_ch.first_start    = out_rsp_ff.first_start;
   assign rsp_ch.first_length   = out_rsp_ff.first_length;
   assign rsp_ch.second_length  = out_rsp_ff.second_length;
   assign rsp_ch.position_after = out_rsp_ff.position_after;

endmodule

@@ verif/circular_log_pointer_controller_core_checker.sv @@
// Checker: watches the channels, predicts each response and compares.
`timescale 1ns / 100ps

module circular_log_pointer_controller_core_checker
   import clpc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   clpc_req_if  req_ch,
   clpc_rsp_if  rsp_ch,
   clpc_csr_if  csr_ch,
   output int   fail_count,
   output int   outstanding,
   output int   checked_count,
   output int   reject_count
);

   typedef logic [LEN_W-1:0] len_type;

   localparam int REPORT_LIMIT = 10;

   // predicted pointer state
   len_type cap_reg;
   len_type cur_pos;
   len_type end_mark;
   logic    wrapped;
   len_type fill_cnt;

   rsp_type log_response_q[$];
   int      n_fail;
   int      n_checked;
   int      n_reject;

   initial begin
      n_fail = 0;
      n_checked = 0;
      n_reject = 0;
   end

   task automatic restart_region();
      cur_pos = '0;
      end_mark = '0;
      wrapped = 1'b0;
      fill_cnt = '0;
   endtask

   // Resolve one request against the predicted pointers and advance them.
   function automatic rsp_type resolve_log_request(input req_type rq);
      rsp_type r;
      int      cap, pos, len, off, fill, held, room, ahead, total, cnt, fl, np;
      bit      ok;
      cap = int'(cap_reg);
      if (cap < 1) cap = 1;
      if (cap > int'(CAPACITY_LIMIT)) cap = int'(CAPACITY_LIMIT);
      pos = int'(cur_pos);
      len = int'(rq.request_length);
      off = int'($signed(rq.seek_offset));
      fill = int'(fill_cnt);
      held = wrapped ? cap : fill;
      // distance from position forward to the logical end, going round the ring
      ahead = (int'(end_mark) >= pos) ? int'(end_mark) - pos : cap - pos + int'(end_mark);
      ok = 1'b0;
      r = '0;
      r.status = STATUS_REJECT;
      r.position_after = cur_pos;
      case (rq.kind)
         KIND_WRITE: begin
            if (len >= 1 && len <= cap) begin
               room = cap - pos;
               if (room >= len) begin
                  fl = len;
                  np = pos + len;
               end else begin
                  fl = room;
                  np = len - room;
                  wrapped = 1'b1;
               end
               if (ahead < len) end_mark = len_type'(np);
               cur_pos = len_type'(np);
               // saturate fill at capacity
               if (fill < cap) fill_cnt = len_type'((fill + len > cap) ? cap : fill + len);
               r.status = STATUS_OK;
               r.transfer_count = len_type'(len);
               r.first_start = len_type'(pos);
               r.first_length = len_type'(fl);
               r.second_length = len_type'(len - fl);
               r.position_after = len_type'(np);
            end
         end
         KIND_READ: begin
            if (len >= 1) begin
               total = (fill < cap) ? fill : cap;
               room = total - pos;
               cnt = (ahead > len) ? len : ahead;
               if (room >= cnt) begin
                  fl = cnt;
                  np = pos + cnt;
                  ok = 1'b1;
               end else if (room >= 0) begin
                  fl = room;
                  np = cnt - room;
                  ok = 1'b1;
               end
               if (ok) begin
                  cur_pos = len_type'(np);
                  r.status = STATUS_OK;
                  r.transfer_count = len_type'(cnt);
                  r.first_start = len_type'(pos);
                  r.first_length = len_type'(fl);
                  r.second_length = len_type'(cnt - fl);
                  r.position_after = len_type'(np);
               end
            end
         end
         KIND_SEEK: begin
            if (rq.seek_whence == WHENCE_END) begin
               if (off <= 0 && held + off >= 0) begin
                  np = int'(end_mark) + off;
                  if (np < 0) np += cap;
                  ok = 1'b1;
               end
            end else if (rq.seek_whence == WHENCE_CURRENT) begin
               if (off <= held && off >= -held) begin
                  np = pos + off;
                  if (np < 0) np += cap;
                  if (np > cap) np -= cap;
                  ok = 1'b1;
               end
            end
            if (ok) begin
               if (np < 0) np = 0;
               if (np > cap) np = cap;
               cur_pos = len_type'(np);
               r.status = STATUS_OK;
               r.position_after = len_type'(np);
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      req_type rq;
      rsp_type got;
      rsp_type want;
      bit      bad;
      if (reset) begin
         cap_reg = CAPACITY_LIMIT;
         restart_region();
         log_response_q.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            cap_reg = csr_ch.capacity;
            restart_region();
         end
         if (req_ch.valid && req_ch.ready) begin
            rq.kind = req_ch.kind;
            rq.request_length = req_ch.request_length;
            rq.seek_offset = req_ch.seek_offset;
            rq.seek_whence = req_ch.seek_whence;
            log_response_q.push_back(resolve_log_request(rq));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.status = rsp_ch.status;
            got.transfer_count = rsp_ch.transfer_count;
            got.first_start = rsp_ch.first_start;
            got.first_length = rsp_ch.first_length;
            got.second_length = rsp_ch.second_length;
            got.position_after = rsp_ch.position_after;
            if (log_response_q.size() == 0) begin
               n_fail++;
               if (n_fail <= REPORT_LIMIT)
                  $display("%0t: response beat with nothing expected: st %0b cnt %0d pos %0d",
                           $time, got.status, got.transfer_count, got.position_after);
            end else begin
               want = log_response_q.pop_front();
               n_checked++;
               if (got.status === STATUS_REJECT) n_reject++;
               bad = (got.status !== want.status)
                  || (got.transfer_count !== want.transfer_count)
                  || (got.first_start !== want.first_start)
                  || (got.first_length !== want.first_length)
                  || (got.second_length !== want.second_length)
                  || (got.position_after !== want.position_after);
               if (bad) begin
                  n_fail++;
                  if (n_fail <= REPORT_LIMIT) begin
                     $display("%0t: response %0d mismatch (exp/act)", $time, n_checked);
                     $display("   st %0b/%0b cnt %0d/%0d start %0d/%0d len1 %0d/%0d",
                              want.status, got.status, want.transfer_count,
                              got.transfer_count, want.first_start, got.first_start,
                              want.first_length, got.first_length);
                     $display("   len2 %0d/%0d pos %0d/%0d", want.second_length,
                              got.second_length, want.position_after, got.position_after);
                  end
               end
            end
         end
      end
      fail_count <= n_fail;
      outstanding <= log_response_q.size();
      checked_count <= n_checked;
      reject_count <= n_reject;
   end

endmodule

@@ verif/circular_log_pointer_controller_core_tb.sv @@
// Testbench top: clock, reset, request and capacity stimulus, response stalls and verdict.
`timescale 1ns / 100ps

module circular_log_pointer_controller_core_tb;
   import clpc_pkg::*;

   localparam logic [CODE_W-1:0] KIND_UNKNOWN = 2'd3;
   localparam logic [CODE_W-1:0] WHENCE_START = 2'd2;
   localparam logic [CODE_W-1:0] WHENCE_BAD   = 2'd3;
   localparam int PHASE_ITEMS = 155;
   localparam int SETTLE_CYCLES = 4;
   localparam int STALL_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset;

   clpc_req_if req_ch ();
   clpc_rsp_if rsp_ch ();
   clpc_csr_if csr_ch ();

   int  fail_count;
   int  outstanding;
   int  checked_count;
   int  reject_count;
   int  n_sent = 0;
   int  n_settings = 0;
   int  cap_now = 65536;
   int  rsp_stall = 0;
   int  quiet_cycles = 0;
   bit  idle_on = 1'b1;
   int  phase_caps [0:8] = '{0, 1, 16, 37, 1000, 65536, 131071, 300, 4096};

   always #1 clock = ~clock;

   circular_log_pointer_controller_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   circular_log_pointer_controller_core_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_ch        (csr_ch),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .checked_count (checked_count),
      .reject_count  (reject_count)
   );

   // response side: stall in short bursts while idling is on
   always @(posedge clock) begin
      if (rsp_stall > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall <= $urandom_range(0, 3);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // watchdog: give up when no beat moves on any channel for too long
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d responses pending",
                  quiet_cycles, outstanding);
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type make_request(input logic [CODE_W-1:0] kind, input int len,
                                            input int off, input logic [CODE_W-1:0] whence);
      req_type rq;
      rq.kind = kind;
      rq.request_length = LEN_W'(len);
      rq.seek_offset = OFF_W'(off);
      rq.seek_whence = whence;
      return rq;
   endfunction

   // mostly short lengths, with the capacity edges mixed in
   function automatic int pick_length(input int cap);
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 5) return $urandom_range(1, (cap < 8) ? cap : 8);
      if (sel < 8) return $urandom_range(1, cap);
      if (sel == 8) return cap;
      return (cap > 1) ? cap - 1 : 1;
   endfunction

   function automatic req_type random_request(input int cap);
      req_type rq;
      int      pick;
      int      off;
      pick = $urandom_range(0, 99);
      rq = make_request(KIND_SEEK, 0, 0, WHENCE_CURRENT);
      if (pick < 8) begin
         // noise: any field pattern, including unknown codes and bad lengths
         rq.kind = CODE_W'($urandom_range(0, 3));
         rq.request_length = LEN_W'($urandom);
         rq.seek_offset = OFF_W'($urandom);
         rq.seek_whence = CODE_W'($urandom_range(0, 3));
      end else if (pick < 48) begin
         rq.kind = KIND_WRITE;
         rq.request_length = LEN_W'(pick_length(cap));
      end else if (pick < 73) begin
         rq.kind = KIND_READ;
         rq.request_length = LEN_W'(($urandom_range(0, 7) == 0) ? int'(CAPACITY_LIMIT)
                                                                 : pick_length(cap));
      end else if ($urandom_range(0, 1) == 0) begin
         rq.seek_whence = WHENCE_END;
         case ($urandom_range(0, 5))
            0: off = 0;
            1: off = $urandom_range(1, 4);
            2: off = -int'($urandom_range(0, (cap < 8) ? cap : 8));
            default: off = -int'($urandom_range(0, cap));
         endcase
         rq.seek_offset = OFF_W'(off);
      end else begin
         if ($urandom_range(0, 1) == 0) off = int'($urandom_range(0, 20)) - 10;
         else off = int'($urandom_range(0, 2 * cap)) - cap;
         rq.seek_offset = OFF_W'(off);
      end
      return rq;
   endfunction

   task automatic send_request(input req_type rq);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind <= rq.kind;
      req_ch.request_length <= rq.request_length;
      req_ch.seek_offset <= rq.seek_offset;
      req_ch.seek_whence <= rq.seek_whence;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      n_sent++;
   endtask

   // hold the request side until every expected response has come back
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_capacity(input int value);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.capacity <= LEN_W'(value);
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      cap_now = value & 32'h1FFFF;
      if (cap_now < 1) cap_now = 1;
      if (cap_now > int'(CAPACITY_LIMIT)) cap_now = int'(CAPACITY_LIMIT);
      n_settings++;
   endtask

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.kind <= KIND_WRITE;
      req_ch.request_length <= '0;
      req_ch.seek_offset <= '0;
      req_ch.seek_whence <= WHENCE_CURRENT;
      csr_ch.valid <= 1'b0;
      csr_ch.capacity <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty ring, bad codes and lengths, position at capacity
      send_request(make_request(KIND_READ, 5, 0, WHENCE_CURRENT));
      send_request(make_request(KIND_WRITE, 0, 0, WHENCE_CURRENT));
      send_request(make_request(KIND_WRITE, 131071, 0, WHENCE_CURRENT));
      send_request(make_request(KIND_READ, 0, 0, WHENCE_CURRENT));
      send_request(make_request(KIND_SEEK, 0, 0, WHENCE_START));
      send_request(make_request(KIND_SEEK, 0, 0, WHENCE_BAD));
      send_request(make_request(KIND_UNKNOWN, 7, 0, WHENCE_CURRENT));
      send_request(make_request(KIND_WRITE, 65536, 0, WHENCE_CURRENT));
      send_request(make_request(KIND_WRITE, 1, 0, WHENCE_CURRENT));
      send_request(make_request(KIND_SEEK, 0, 0, WHENCE_END));
      send_request(make_request(KIND_SEEK, 0, 1, WHENCE_END));
      send_request(make_request(KIND_SEEK, 0, -65536, WHENCE_END));
      send_request(make_request(KIND_SEEK, 0, -131072, WHENCE_END));
      send_request(make_request(KIND_SEEK, 0, 131071, WHENCE_CURRENT));
      send_request(make_request(KIND_SEEK, 0, -100, WHENCE_CURRENT));
      send_request(make_request(KIND_READ, 65536, 0, WHENCE_CURRENT));

      // directed: small region, read past the filled part, full-size write
      write_capacity(100);
      send_request(make_request(KIND_WRITE, 10, 0, WHENCE_CURRENT));
      send_request(make_request(KIND_SEEK, 0, 10, WHENCE_CURRENT));
      send_request(make_request(KIND_READ, 5, 0, WHENCE_CURRENT));
      send_request(make_request(KIND_SEEK, 0, -20, WHENCE_CURRENT));
      send_request(make_request(KIND_READ, 100, 0, WHENCE_CURRENT));
      send_request(make_request(KIND_WRITE, 100, 0, WHENCE_CURRENT));
      send_request(make_request(KIND_WRITE, 101, 0, WHENCE_CURRENT));

      // random phases, one capacity each; the last one runs without idling
      phase_caps[7] = $urandom_range(2, 65535);
      for (int p = 0; p < 9; p++) begin
         write_capacity(phase_caps[p]);
         if (p == 8) idle_on = 1'b0;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i == PHASE_ITEMS / 2) drain_results();
            send_request(random_request(cap_now));
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES * 2) @(posedge clock);
      $display("Covered %0d requests over %0d capacity settings, extremes included.",
               n_sent, n_settings);
      $display("Checked %0d responses, %0d of them rejections.", checked_count, reject_count);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("Verification failed");
      end
      $finish;
   end

endmodule
